// ===== src/mpc_pkg.sv =====
`default_nettype none
// shared types, constants and helpers for the mecanum p-control step
package mpc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 24;
  localparam int YAW_W      = 20;
  localparam int KP_W       = 24;
  localparam int GAIN_W     = 32;
  localparam int LIM_W      = 15;
  localparam int WHEEL_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LANES      = 4;

  localparam int ERR_W      = POS_W + 1;
  localparam int ERRA_W     = YAW_W + 1;
  localparam int PROD_W     = ERR_W + KP_W + 1;
  localparam int CMD_W      = 30;
  localparam int ANG_W      = 36;
  localparam int YAW_SHIFT  = 30 - FRAC_BITS;
  localparam int CXY_W      = 33;
  localparam int TRIG_W     = 27;
  localparam int TRIG_SHIFT = 6;
  localparam int MAX_ITER   = 24;
  localparam int ATAN_W     = 32;
  localparam int ROTP_W     = TRIG_W + CMD_W;
  localparam int ROT_SHIFT  = 24;
  localparam int LIN_W      = CMD_W + 1;
  localparam int GP_W       = GAIN_W + 1 + LIN_W + 1;
  localparam int WIDE_W     = 66;
  localparam int WQ_W       = 48;
  localparam int MAG_W      = WQ_W - 1;
  localparam int NUM_W      = MAG_W + LIM_W;

  localparam int TOL_XY  = (2 << FRAC_BITS) / 1000;
  localparam int TOL_YAW = (17 << FRAC_BITS) / 10000;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CXY_W-1:0] CORDIC_K    = 33'sd652032874;
  localparam logic signed [CMD_W-1:0] CMD_SAT     = 30'sd536870911;
  localparam logic signed [WQ_W-1:0]  WHEEL_SAT   = 48'sd140737488355327;
  localparam logic [LANES-1:0]        INV_LANES   = 4'b0110;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GOAL_X, CFG_GOAL_Y, CFG_GOAL_YAW, CFG_KP_XY,
    CFG_KP_YAW, CFG_WHEEL_GAIN, CFG_TURN_GAIN, CFG_MOTOR_LIMIT
  } cfg_idx_e;

  typedef struct packed {
    logic signed [POS_W-1:0] goal_x;
    logic signed [POS_W-1:0] goal_y;
    logic signed [YAW_W-1:0] goal_yaw;
    logic [KP_W-1:0]         kp_xy;
    logic [KP_W-1:0]         kp_yaw;
    logic [GAIN_W-1:0]       wheel_gain;
    logic [GAIN_W-1:0]       turn_gain;
    logic [LIM_W-1:0]        motor_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    goal_x: 24'sd22938, goal_y: 24'sd3277, goal_yaw: 20'sd0,
    kp_xy: 24'd65536, kp_yaw: 24'd65536, wheel_gain: 32'd65536,
    turn_gain: 32'd65536, motor_limit: 15'd32767
  };

  typedef struct packed {
    logic                    tol;
    logic signed [CMD_W-1:0] vx;
    logic signed [CMD_W-1:0] vy;
    logic signed [CMD_W-1:0] wz;
  } cmd_t;

  typedef struct packed {
    logic                         tol;
    logic                         limited;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0][MAG_W-1:0]  mag;
    logic [MAG_W-1:0]             peak;
  } mag_t;

  function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
    unique case (idx)
      5'd0:  return 32'd843314857;
      5'd1:  return 32'd497837829;
      5'd2:  return 32'd263043837;
      5'd3:  return 32'd133525159;
      5'd4:  return 32'd67021687;
      5'd5:  return 32'd33543516;
      5'd6:  return 32'd16775851;
      5'd7:  return 32'd8388437;
      5'd8:  return 32'd4194283;
      5'd9:  return 32'd2097149;
      5'd10: return 32'd1048576;
      5'd11: return 32'd524288;
      5'd12: return 32'd262144;
      5'd13: return 32'd131072;
      5'd14: return 32'd65536;
      5'd15: return 32'd32768;
      5'd16: return 32'd16384;
      5'd17: return 32'd8192;
      5'd18: return 32'd4096;
      5'd19: return 32'd2048;
      5'd20: return 32'd1024;
      5'd21: return 32'd512;
      5'd22: return 32'd256;
      5'd23: return 32'd128;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [WIDE_W-1:0] v);
    if (v > WIDE_W'(CMD_SAT)) return CMD_SAT;
    else if (v < -WIDE_W'(CMD_SAT)) return -CMD_SAT;
    else return v[CMD_W-1:0];
  endfunction

  function automatic logic signed [WQ_W-1:0] sat_wheel(input logic signed [WIDE_W-1:0] v);
    if (v > WIDE_W'(WHEEL_SAT)) return WHEEL_SAT;
    else if (v < -WIDE_W'(WHEEL_SAT)) return -WHEEL_SAT;
    else return v[WQ_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/mpc_cmd.sv =====
`default_nettype none
// pose error, tolerance test, p command and yaw range reduction
module mpc_cmd (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                valid_i,
  input  wire logic signed [mpc_pkg::POS_W-1:0] pose_x_i,
  input  wire logic signed [mpc_pkg::POS_W-1:0] pose_y_i,
  input  wire logic signed [mpc_pkg::YAW_W-1:0] yaw_i,
  input  wire mpc_pkg::cfg_t                 cfg_i,
  output logic                               valid_o,
  output mpc_pkg::cmd_t                      cmd_o,
  output logic signed [mpc_pkg::ANG_W-1:0]   angle_o,
  output logic                               flip_o
);
  import mpc_pkg::*;

  logic signed [ERR_W-1:0]  ex_d, ex_q, ey_d, ey_q;
  logic signed [ERRA_W-1:0] ea_d, ea_q;
  logic signed [ANG_W-1:0]  ang0, ang_a_d, ang_a_q, ang_b_d, ang_b_q;
  logic                     tol_a_d, tol_a_q, tol_b_q, flip_b_d, flip_b_q;
  logic signed [PROD_W-1:0] px_d, py_d, pa_d, px_q, py_q, pa_q;
  logic [2:0]               vld_q;

  assign ex_d = ERR_W'(cfg_i.goal_x) - ERR_W'(pose_x_i);
  assign ey_d = ERR_W'(cfg_i.goal_y) - ERR_W'(pose_y_i);
  assign ea_d = ERRA_W'(cfg_i.goal_yaw) + ERRA_W'(yaw_i);
  assign tol_a_d = (ex_d > -ERR_W'(TOL_XY)) && (ex_d < ERR_W'(TOL_XY)) &&
                   (ey_d > -ERR_W'(TOL_XY)) && (ey_d < ERR_W'(TOL_XY)) &&
                   (ea_d > -ERRA_W'(TOL_YAW)) && (ea_d < ERRA_W'(TOL_YAW));
  assign ang0 = ANG_W'(yaw_i) <<< YAW_SHIFT;

  always_comb begin
    if (ang0 > PI_Q30) begin
      ang_a_d = ang0 - TWO_PI_Q30;
    end else if (ang0 < -PI_Q30) begin
      ang_a_d = ang0 + TWO_PI_Q30;
    end else begin
      ang_a_d = ang0;
    end
  end

  always_comb begin
    flip_b_d = 1'b1;
    if (ang_a_q > HALF_PI_Q30) begin
      ang_b_d = ang_a_q - PI_Q30;
    end else if (ang_a_q < -HALF_PI_Q30) begin
      ang_b_d = ang_a_q + PI_Q30;
    end else begin
      ang_b_d = ang_a_q;
      flip_b_d = 1'b0;
    end
  end

  assign px_d = $signed({1'b0, cfg_i.kp_xy}) * ex_q;
  assign py_d = $signed({1'b0, cfg_i.kp_xy}) * ey_q;
  assign pa_d = $signed({1'b0, cfg_i.kp_yaw}) * ea_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ex_q    <= ex_d;
    ey_q    <= ey_d;
    ea_q    <= ea_d;
    tol_a_q <= tol_a_d;
    ang_a_q <= ang_a_d;
    px_q     <= px_d;
    py_q     <= py_d;
    pa_q     <= pa_d;
    tol_b_q  <= tol_a_q;
    ang_b_q  <= ang_b_d;
    flip_b_q <= flip_b_d;
    cmd_o.tol <= tol_b_q;
    cmd_o.vx  <= sat_cmd((-WIDE_W'(px_q)) >>> FRAC_BITS);
    cmd_o.vy  <= sat_cmd((-WIDE_W'(py_q)) >>> FRAC_BITS);
    cmd_o.wz  <= sat_cmd((-WIDE_W'(pa_q)) >>> FRAC_BITS);
    angle_o   <= ang_b_q;
    flip_o    <= flip_b_q;
  end

  assign valid_o = vld_q[2];

endmodule
`default_nettype wire

// ===== src/mpc_cordic.sv =====
`default_nettype none
// pipelined rotation-mode cordic, one iteration per stage
module mpc_cordic #(
  parameter int unsigned ITER = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               valid_i,
  input  wire mpc_pkg::cmd_t                cmd_i,
  input  wire logic signed [mpc_pkg::ANG_W-1:0] angle_i,
  input  wire                               flip_i,
  output logic                              valid_o,
  output mpc_pkg::cmd_t                     cmd_o,
  output logic signed [mpc_pkg::TRIG_W-1:0] sin_o,
  output logic signed [mpc_pkg::TRIG_W-1:0] cos_o
);
  import mpc_pkg::*;

  logic [ITER:0]            vld_q;
  logic [ITER:0]            flip_q;
  logic signed [CXY_W-1:0]  x_q [ITER+1];
  logic signed [CXY_W-1:0]  y_q [ITER+1];
  logic signed [ANG_W-1:0]  a_q [ITER+1];
  cmd_t                     cmd_q [ITER+1];
  logic signed [CXY_W-1:0]  xf, yf;
  logic                     vld_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[ITER-1:0], valid_i};
      vld_out_q <= vld_q[ITER];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= CORDIC_K;
    y_q[0]    <= '0;
    a_q[0]    <= angle_i;
    flip_q[0] <= flip_i;
    cmd_q[0]  <= cmd_i;
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    logic signed [CXY_W-1:0] xs, ys;
    logic signed [ANG_W-1:0] at;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = ANG_W'(atan_q30(5'(i)));

    always_ff @(posedge clk_i) begin
      if (a_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        a_q[i+1] <= a_q[i] - at;
      end else begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        a_q[i+1] <= a_q[i] + at;
      end
      flip_q[i+1] <= flip_q[i];
      cmd_q[i+1]  <= cmd_q[i];
    end
  end

  assign xf = flip_q[ITER] ? -x_q[ITER] : x_q[ITER];
  assign yf = flip_q[ITER] ? -y_q[ITER] : y_q[ITER];

  always_ff @(posedge clk_i) begin
    cos_o <= TRIG_W'(xf >>> TRIG_SHIFT);
    sin_o <= TRIG_W'(yf >>> TRIG_SHIFT);
    cmd_o <= cmd_q[ITER];
  end

  assign valid_o = vld_out_q;

endmodule
`default_nettype wire

// ===== src/mpc_kin.sv =====
`default_nettype none
// command rotation, mecanum wheel mixing and peak magnitude search
module mpc_kin (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               valid_i,
  input  wire mpc_pkg::cmd_t                cmd_i,
  input  wire logic signed [mpc_pkg::TRIG_W-1:0] sin_i,
  input  wire logic signed [mpc_pkg::TRIG_W-1:0] cos_i,
  input  wire logic [mpc_pkg::GAIN_W-1:0]   wheel_gain_i,
  input  wire logic [mpc_pkg::GAIN_W-1:0]   turn_gain_i,
  input  wire logic [mpc_pkg::LIM_W-1:0]    motor_limit_i,
  output logic                              valid_o,
  output mpc_pkg::mag_t                     mag_o
);
  import mpc_pkg::*;

  logic [5:0]               vld_q;
  logic signed [ROTP_W-1:0] pcx_q, psy_q, pcy_q, psx_q;
  logic signed [CMD_W-1:0]  rx_q, ry_q, wz1_q, wz2_q, wz3_q;
  logic signed [LIN_W-1:0]  lm_q, lp_q;
  logic signed [GP_W-1:0]   gm_q, gp_q, tw_q;
  logic signed [WQ_W-1:0]   w_q [LANES];
  logic [5:0]               tol_q;
  logic [LANES-1:0][MAG_W-1:0] mag_d;
  logic [LANES-1:0]         neg_d;
  logic [MAG_W-1:0]         m01, m23, peak_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tol_q <= {tol_q[4:0], cmd_i.tol};
    pcx_q <= cos_i * cmd_i.vx;
    psy_q <= sin_i * cmd_i.vy;
    pcy_q <= cos_i * cmd_i.vy;
    psx_q <= sin_i * cmd_i.vx;
    wz1_q <= cmd_i.wz;
    rx_q  <= sat_cmd(WIDE_W'(pcx_q + psy_q) >>> ROT_SHIFT);
    ry_q  <= sat_cmd(WIDE_W'(pcy_q - psx_q) >>> ROT_SHIFT);
    wz2_q <= wz1_q;
    lm_q  <= LIN_W'(rx_q) - LIN_W'(ry_q);
    lp_q  <= LIN_W'(rx_q) + LIN_W'(ry_q);
    wz3_q <= wz2_q;
    gm_q  <= $signed({1'b0, wheel_gain_i}) * lm_q;
    gp_q  <= $signed({1'b0, wheel_gain_i}) * lp_q;
    tw_q  <= $signed({1'b0, turn_gain_i}) * wz3_q;
    w_q[0] <= sat_wheel((WIDE_W'(gm_q) - WIDE_W'(tw_q)) >>> FRAC_BITS);
    w_q[1] <= sat_wheel((WIDE_W'(gp_q) + WIDE_W'(tw_q)) >>> FRAC_BITS);
    w_q[2] <= sat_wheel((WIDE_W'(gm_q) + WIDE_W'(tw_q)) >>> FRAC_BITS);
    w_q[3] <= sat_wheel((WIDE_W'(gp_q) - WIDE_W'(tw_q)) >>> FRAC_BITS);
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      neg_d[k] = w_q[k] < 0;
      mag_d[k] = neg_d[k] ? MAG_W'(-w_q[k]) : MAG_W'(w_q[k]);
    end
  end

  assign m01    = (mag_d[1] > mag_d[0]) ? mag_d[1] : mag_d[0];
  assign m23    = (mag_d[3] > mag_d[2]) ? mag_d[3] : mag_d[2];
  assign peak_d = (m23 > m01) ? m23 : m01;

  always_ff @(posedge clk_i) begin
    mag_o.tol     <= tol_q[4];
    mag_o.neg     <= neg_d;
    mag_o.mag     <= mag_d;
    mag_o.peak    <= peak_d;
    mag_o.limited <= peak_d > (MAG_W'(motor_limit_i) << FRAC_BITS);
  end

  assign valid_o = vld_q[5];

endmodule
`default_nettype wire

// ===== src/mpc_limit.sv =====
`default_nettype none
// speed limit scaling by a pipelined restoring divider and output stage
module mpc_limit (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               valid_i,
  input  wire mpc_pkg::mag_t                mag_i,
  input  wire logic [mpc_pkg::LIM_W-1:0]    motor_limit_i,
  output logic                              done_o,
  output logic [mpc_pkg::LANES-1:0][mpc_pkg::WHEEL_W-1:0] wheel_o,
  output logic                              at_goal_o
);
  import mpc_pkg::*;

  typedef struct packed {
    logic                        tol;
    logic                        limited;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][LIM_W-1:0] tr;
    logic [MAG_W-1:0]            peak;
  } side_t;

  logic [LIM_W:0]       vld_q;
  logic                 done_q;
  side_t                side_q [LIM_W+1];
  logic [NUM_W-1:0]     r_q [LIM_W+1][LANES];
  logic [LIM_W-1:0]     q_q [LIM_W+1][LANES];
  side_t                side_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[LIM_W-1:0], valid_i};
      done_q <= vld_q[LIM_W];
    end
  end

  always_comb begin
    side_d.tol     = mag_i.tol;
    side_d.limited = mag_i.limited;
    side_d.neg     = mag_i.neg;
    side_d.peak    = mag_i.peak;
    for (int k = 0; k < LANES; k++) begin
      side_d.tr[k] = mag_i.mag[k][LIM_W+FRAC_BITS-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int k = 0; k < LANES; k++) begin
      r_q[0][k] <= NUM_W'(mag_i.mag[k]) * NUM_W'(motor_limit_i);
      q_q[0][k] <= '0;
    end
  end

  for (genvar j = 0; j < LIM_W; j++) begin : g_div
    logic [NUM_W-1:0] dv;
    assign dv = NUM_W'(side_q[j].peak) << (LIM_W - 1 - j);

    always_ff @(posedge clk_i) begin
      side_q[j+1] <= side_q[j];
      for (int k = 0; k < LANES; k++) begin
        if (r_q[j][k] >= dv) begin
          r_q[j+1][k] <= r_q[j][k] - dv;
          q_q[j+1][k] <= {q_q[j][k][LIM_W-2:0], 1'b1};
        end else begin
          r_q[j+1][k] <= r_q[j][k];
          q_q[j+1][k] <= {q_q[j][k][LIM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LANES; k++) begin
      logic [LIM_W-1:0] mg;
      mg = side_q[LIM_W].limited ? q_q[LIM_W][k] : side_q[LIM_W].tr[k];
      if (side_q[LIM_W].tol) begin
        wheel_o[k] <= '0;
      end else if (side_q[LIM_W].neg[k] ^ INV_LANES[k]) begin
        wheel_o[k] <= -{1'b0, mg};
      end else begin
        wheel_o[k] <= {1'b0, mg};
      end
    end
    at_goal_o <= side_q[LIM_W].tol;
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== src/mecanum_p_control_step.sv =====
`default_nettype none
// top level: mecanum p-control step from measured pose to four wheel commands
//
// a pose word is taken on a rising edge with start_i high and busy_o low;
// busy_o stays low, so a new pose may be given in every cycle.
// configuration words arrive on the cfg channel (valid/ready, index and data);
// ready is always high and writes belong between bursts of poses.
// each result appears on the wheel and at_goal ports for one cycle with done_o
// high. the stages are three for error and p command, one per cordic iteration
// plus two, six for rotation, mixing and peak search, and one per quotient
// bit of the limit divider (15) plus two.
// throughput is one word per cycle.
// there is no back-pressure: the receiver must take each result when shown.
// reset clears all valid bits, so nothing in flight survives it, and loads the
// default goal, gains and limit.
module mecanum_p_control_step #(
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    start_i,
  output logic                                   busy_o,
  input  wire logic signed [mpc_pkg::POS_W-1:0]  pose_x_i,
  input  wire logic signed [mpc_pkg::POS_W-1:0]  pose_y_i,
  input  wire logic signed [mpc_pkg::YAW_W-1:0]  yaw_i,
  input  wire                                    cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mpc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [mpc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                                   done_o,
  output logic signed [mpc_pkg::WHEEL_W-1:0]     wheel_0_o,
  output logic signed [mpc_pkg::WHEEL_W-1:0]     wheel_1_o,
  output logic signed [mpc_pkg::WHEEL_W-1:0]     wheel_2_o,
  output logic signed [mpc_pkg::WHEEL_W-1:0]     wheel_3_o,
  output logic                                   at_goal_o
);
  import mpc_pkg::*;

  localparam int LATENCY = 13 + LIM_W + TRIG_ITERATIONS;

  cfg_t                     cfg_q;
  logic                     accept;
  logic                     cmd_vld, cor_vld, kin_vld;
  cmd_t                     cmd_w, cor_cmd;
  logic signed [ANG_W-1:0]  angle_w;
  logic                     flip_w;
  logic signed [TRIG_W-1:0] sin_w, cos_w;
  mag_t                     mag_w;
  logic [LANES-1:0][WHEEL_W-1:0] wheel_w;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GOAL_X:      cfg_q.goal_x      <= cfg_data_i[POS_W-1:0];
        CFG_GOAL_Y:      cfg_q.goal_y      <= cfg_data_i[POS_W-1:0];
        CFG_GOAL_YAW:    cfg_q.goal_yaw    <= cfg_data_i[YAW_W-1:0];
        CFG_KP_XY:       cfg_q.kp_xy       <= cfg_data_i[KP_W-1:0];
        CFG_KP_YAW:      cfg_q.kp_yaw      <= cfg_data_i[KP_W-1:0];
        CFG_WHEEL_GAIN:  cfg_q.wheel_gain  <= cfg_data_i[GAIN_W-1:0];
        CFG_TURN_GAIN:   cfg_q.turn_gain   <= cfg_data_i[GAIN_W-1:0];
        CFG_MOTOR_LIMIT: cfg_q.motor_limit <= cfg_data_i[LIM_W-1:0];
      endcase
    end
  end

  mpc_cmd u_cmd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .pose_x_i (pose_x_i),
    .pose_y_i (pose_y_i),
    .yaw_i    (yaw_i),
    .cfg_i    (cfg_q),
    .valid_o  (cmd_vld),
    .cmd_o    (cmd_w),
    .angle_o  (angle_w),
    .flip_o   (flip_w)
  );

  mpc_cordic #(
    .ITER (TRIG_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmd_vld),
    .cmd_i   (cmd_w),
    .angle_i (angle_w),
    .flip_i  (flip_w),
    .valid_o (cor_vld),
    .cmd_o   (cor_cmd),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  mpc_kin u_kin (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (cor_vld),
    .cmd_i         (cor_cmd),
    .sin_i         (sin_w),
    .cos_i         (cos_w),
    .wheel_gain_i  (cfg_q.wheel_gain),
    .turn_gain_i   (cfg_q.turn_gain),
    .motor_limit_i (cfg_q.motor_limit),
    .valid_o       (kin_vld),
    .mag_o         (mag_w)
  );

  mpc_limit u_limit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (kin_vld),
    .mag_i         (mag_w),
    .motor_limit_i (cfg_q.motor_limit),
    .done_o        (done_o),
    .wheel_o       (wheel_w),
    .at_goal_o     (at_goal_o)
  );

  assign wheel_0_o = wheel_w[0];
  assign wheel_1_o = wheel_w[1];
  assign wheel_2_o = wheel_w[2];
  assign wheel_3_o = wheel_w[3];

  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("result missing after accepted pose");

  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result without an accepted pose");

  a_goal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && at_goal_o |-> wheel_0_o == 0 && wheel_1_o == 0 &&
                            wheel_2_o == 0 && wheel_3_o == 0)
    else $error("nonzero wheel at goal");

endmodule
`default_nettype wire
